// ===== rtl/core/ordered_key_list_unit_macros.svh =====
// ----------------------------------------------------------------------------
// ordered_key_list_unit_macros: assertion macros for the ordered key list
// Each macro expands to one labeled concurrent assertion that is sampled on
// clk and switched off while rst is high.
// ----------------------------------------------------------------------------
`ifndef ORDERED_KEY_LIST_UNIT_MACROS_SVH
`define ORDERED_KEY_LIST_UNIT_MACROS_SVH

// same-cycle implication
`define OKL_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OKL_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/okl_pkg.sv =====
// ----------------------------------------------------------------------------
// okl_pkg: shared types and codes of the ordered key list
// Action and status codes, controller states and the command / status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package okl_pkg;

  localparam int KEY_W    = 32;
  localparam int ACTION_W = 3;
  localparam int STATUS_W = 2;

  // request action codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_REMOVE     = 3'd4,
    ACT_LIST       = 3'd5
  } action_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_SCAN,
    S_SHIFT,
    S_RM_DONE,
    S_NOT_FOUND,
    S_LIST
  } state_t;

  // list position that the memory read port looks at
  typedef enum logic [1:0] {
    RD_FIRST,
    RD_LAST,
    RD_NEXT,
    RD_NEXT2
  } rd_sel_t;

  // memory write address and data source
  typedef enum logic [1:0] {
    WR_FRONT,
    WR_BACK,
    WR_SHIFT
  } wr_sel_t;

  // front pointer and count update
  typedef enum logic [2:0] {
    CNT_HOLD,
    CNT_PUSH_FRONT,
    CNT_PUSH_BACK,
    CNT_POP_FRONT,
    CNT_DEC
  } cnt_op_t;

  // source of the result key
  typedef enum logic [1:0] {
    KEY_ZERO,
    KEY_RDATA,
    KEY_IN
  } key_sel_t;

  typedef struct packed {
    logic     in_ready;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     wr_en;
    wr_sel_t  wr_sel;
    cnt_op_t  cnt_op;
    logic     pos_clr;
    logic     pos_inc;
    logic     emit;
    status_t  status;
    key_sel_t key_sel;
    logic     last;
  } cmd_t;

  typedef struct packed {
    logic    in_valid;
    logic    out_free;
    action_t action;
    logic    empty;
    logic    full;
    logic    match;
    logic    pos_last;
    logic    next2_ok;
  } sts_t;

endpackage

// ===== rtl/core/okl_item_if.sv =====
// ----------------------------------------------------------------------------
// okl_item_if: request channel of the ordered key list
// Valid / ready handshake carrying one action and one key.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface okl_item_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [31:0] key;

  modport source (output valid, output action, output key, input ready);
  modport sink   (input valid, input action, input key, output ready);
endinterface

// ===== rtl/core/okl_result_if.sv =====
// ----------------------------------------------------------------------------
// okl_result_if: result channel of the ordered key list
// Valid / ready handshake carrying status, key, count and last flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface okl_result_if #(
  parameter int CountW = 5
);
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [31:0]       key_out;
  logic [CountW-1:0] member_count;
  logic              last;

  modport source (output valid, output status, output key_out, output member_count,
                  output last, input ready);
  modport sink   (input valid, input status, input key_out, input member_count,
                  input last, output ready);
endinterface

// ===== rtl/core/okl_ctrl.sv =====
// ----------------------------------------------------------------------------
// okl_ctrl: sequencer of the ordered key list
// Decodes each request and steps the datapath through reads, shifts and
// result emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module okl_ctrl import okl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.rd_sel  = RD_FIRST;
    cmd.wr_sel  = WR_FRONT;
    cmd.cnt_op  = CNT_HOLD;
    cmd.status  = STAT_OK;
    cmd.key_sel = KEY_ZERO;
    cmd.last    = 1'b1;
    case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.action)
          ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
            if (sts.out_free) begin
              cmd.emit   = 1'b1;
              state_next = S_IDLE;
              if (sts.full) begin
                cmd.status = STAT_FULL;
              end else begin
                cmd.wr_en = 1'b1;
                if (sts.action == ACT_PUSH_FRONT) begin
                  cmd.wr_sel = WR_FRONT;
                  cmd.cnt_op = CNT_PUSH_FRONT;
                end else begin
                  cmd.wr_sel = WR_BACK;
                  cmd.cnt_op = CNT_PUSH_BACK;
                end
              end
            end
          end
          ACT_POP_FRONT, ACT_POP_BACK: begin
            if (sts.empty) begin
              if (sts.out_free) begin
                cmd.emit   = 1'b1;
                cmd.status = STAT_EMPTY;
                state_next = S_IDLE;
              end
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = (sts.action == ACT_POP_FRONT) ? RD_FIRST : RD_LAST;
              state_next = S_POP;
            end
          end
          ACT_REMOVE: begin
            if (sts.empty) begin
              if (sts.out_free) begin
                cmd.emit   = 1'b1;
                cmd.status = STAT_NOT_FOUND;
                state_next = S_IDLE;
              end
            end else begin
              cmd.rd_en   = 1'b1;
              cmd.rd_sel  = RD_FIRST;
              cmd.pos_clr = 1'b1;
              state_next  = S_SCAN;
            end
          end
          ACT_LIST: begin
            if (sts.empty) begin
              if (sts.out_free) begin
                cmd.emit   = 1'b1;
                cmd.status = STAT_EMPTY;
                state_next = S_IDLE;
              end
            end else begin
              cmd.rd_en   = 1'b1;
              cmd.rd_sel  = RD_FIRST;
              cmd.pos_clr = 1'b1;
              state_next  = S_LIST;
            end
          end
          default: begin
            // unused action codes give a plain ok
            if (sts.out_free) begin
              cmd.emit   = 1'b1;
              state_next = S_IDLE;
            end
          end
        endcase
      end
      S_POP: begin
        if (sts.out_free) begin
          cmd.emit    = 1'b1;
          cmd.key_sel = KEY_RDATA;
          cmd.cnt_op  = (sts.action == ACT_POP_FRONT) ? CNT_POP_FRONT : CNT_DEC;
          state_next  = S_IDLE;
        end
      end
      S_SCAN: begin
        // read data holds the entry at pos
        if (sts.match) begin
          if (sts.pos_last) begin
            state_next = S_RM_DONE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_NEXT;
            state_next = S_SHIFT;
          end
        end else if (sts.pos_last) begin
          state_next = S_NOT_FOUND;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RD_NEXT;
          cmd.pos_inc = 1'b1;
        end
      end
      S_SHIFT: begin
        // move the entry at pos + 1 down into pos
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_SHIFT;
        cmd.pos_inc = 1'b1;
        if (sts.next2_ok) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_NEXT2;
        end else begin
          state_next = S_RM_DONE;
        end
      end
      S_RM_DONE: begin
        if (sts.out_free) begin
          cmd.emit    = 1'b1;
          cmd.key_sel = KEY_IN;
          cmd.cnt_op  = CNT_DEC;
          state_next  = S_IDLE;
        end
      end
      S_NOT_FOUND: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.status = STAT_NOT_FOUND;
          state_next = S_IDLE;
        end
      end
      S_LIST: begin
        if (sts.out_free) begin
          cmd.emit    = 1'b1;
          cmd.key_sel = KEY_RDATA;
          cmd.last    = sts.pos_last;
          if (sts.pos_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = RD_NEXT;
            cmd.pos_inc = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/okl_dp.sv =====
// ----------------------------------------------------------------------------
// okl_dp: datapath of the ordered key list
// Circular key memory, front pointer, count, walk position, request latch
// and result output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module okl_dp import okl_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  okl_item_if.sink            in_ch,
  okl_result_if.source        out_ch,
  input  cmd_t                cmd,
  output sts_t                sts
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [KEY_W-1:0]    mem [DEPTH];
  logic [KEY_W-1:0]    rdata;
  logic [ACTION_W-1:0] act;
  logic [KEY_W-1:0]    key;
  logic [IW-1:0]       front;
  logic [IW-1:0]       front_next;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [CW-1:0]       pos;
  logic [IW-1:0]       front_inc;
  logic [IW-1:0]       front_dec;
  logic [CW-1:0]       rd_rel;
  logic [IW-1:0]       rd_addr;
  logic [IW-1:0]       wr_addr;
  logic [KEY_W-1:0]    wr_data;
  logic [CW:0]         pos_p1;
  logic [CW:0]         pos_p2;
  logic                out_valid;
  status_t             out_status;
  logic [KEY_W-1:0]    out_key;
  logic [CW-1:0]       out_count;
  logic                out_last;
  logic                out_free;

  // slot of a list position, modulo DEPTH by one compare and subtract
  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
                                            input logic [IW-1:0] off);
    logic [IW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IW+1)'(DEPTH)) begin
      sum = sum - (IW+1)'(DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  // request latch, closed while reset is held
  assign in_ch.ready = cmd.in_ready && !rst;

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      act <= in_ch.action;
      key <= in_ch.key;
    end
  end

  // front pointer and count
  assign front_inc = (front == IW'(DEPTH - 1)) ? '0 : front + IW'(1);
  assign front_dec = (front == '0) ? IW'(DEPTH - 1) : front - IW'(1);

  always_comb begin
    front_next = front;
    count_next = count;
    case (cmd.cnt_op)
      CNT_PUSH_FRONT: begin
        front_next = front_dec;
        count_next = count + CW'(1);
      end
      CNT_PUSH_BACK: begin
        count_next = count + CW'(1);
      end
      CNT_POP_FRONT: begin
        front_next = front_inc;
        count_next = count - CW'(1);
      end
      CNT_DEC: begin
        count_next = count - CW'(1);
      end
      default: begin
        front_next = front;
        count_next = count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else begin
      front <= front_next;
      count <= count_next;
    end
  end

  // walk position
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (cmd.pos_clr) begin
      pos <= '0;
    end else if (cmd.pos_inc) begin
      pos <= pos + CW'(1);
    end
  end

  assign pos_p1 = {1'b0, pos} + (CW+1)'(1);
  assign pos_p2 = {1'b0, pos} + (CW+1)'(2);

  // memory addresses
  always_comb begin
    case (cmd.rd_sel)
      RD_FIRST: rd_rel = '0;
      RD_LAST:  rd_rel = count - CW'(1);
      RD_NEXT:  rd_rel = pos_p1[CW-1:0];
      RD_NEXT2: rd_rel = pos_p2[CW-1:0];
      default:  rd_rel = '0;
    endcase
  end

  assign rd_addr = slot_of(front, rd_rel[IW-1:0]);

  always_comb begin
    case (cmd.wr_sel)
      WR_FRONT: begin
        wr_addr = front_dec;
        wr_data = key;
      end
      WR_BACK: begin
        wr_addr = slot_of(front, count[IW-1:0]);
        wr_data = key;
      end
      WR_SHIFT: begin
        wr_addr = slot_of(front, pos[IW-1:0]);
        wr_data = rdata;
      end
      default: begin
        wr_addr = front_dec;
        wr_data = key;
      end
    endcase
  end

  // key memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // result output register
  assign out_free = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= cmd.status;
      out_count  <= count_next;
      out_last   <= cmd.last;
      case (cmd.key_sel)
        KEY_RDATA: out_key <= rdata;
        KEY_IN:    out_key <= key;
        default:   out_key <= '0;
      endcase
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.status       = out_status;
  assign out_ch.key_out      = out_key;
  assign out_ch.member_count = out_count;
  assign out_ch.last         = out_last;

  // status to the controller
  assign sts.in_valid = in_ch.valid;
  assign sts.out_free = out_free;
  assign sts.action   = action_t'(act);
  assign sts.empty    = (count == '0);
  assign sts.full     = (count == CW'(DEPTH));
  assign sts.match    = (rdata == key);
  assign sts.pos_last = (pos_p1 == {1'b0, count});
  assign sts.next2_ok = (pos_p2 < {1'b0, count});

endmodule

// ===== rtl/core/ordered_key_list_unit.sv =====
// ----------------------------------------------------------------------------
// ordered_key_list_unit: ordered list of keys with removal by key
// Top level joining the sequencer and the datapath of the key list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ordered_key_list_unit_macros.svh"

// Holds up to DEPTH 32-bit keys in a circular single-port-read memory and
// takes one request at a time. Pushes, unused action codes and any request
// on an empty list give their result straight from the decode state; a pop
// first reads the entry and then gives it as the result; a list reads the
// entries in order and gives one result for each; a remove by key scans from the
// front one entry per cycle and then moves each later entry down one slot
// per cycle. This pacing is set by the one read and one write port of the
// key memory. The next request can be taken in the same cycle that the last
// result of the previous one first sits in the output register, and a
// stalled result channel holds the list walk. The key memory is not cleared
// at reset and needs no clearing pass; only entries inside the list are ever read.
module ordered_key_list_unit import okl_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  okl_item_if.sink     in_ch,
  okl_result_if.source out_ch
);

  cmd_t cmd;
  sts_t sts;

  okl_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  okl_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

  // one request in flight at a time
  `OKL_ASSERT_NEXT(a_one_request, in_ch.valid && in_ch.ready, !in_ch.ready, "request taken while busy")
  // results are only loaded into a free output register
  `OKL_ASSERT_NOW(a_emit_free, cmd.emit, sts.out_free, "result overwrote a pending result")
  // only the final result of a list may be non-ok
  `OKL_ASSERT_NOW(a_mid_ok, out_ch.valid && !out_ch.last, out_ch.status == STAT_OK, "non-final result not ok")
  // count never goes past the capacity
  `OKL_ASSERT_NOW(a_count_cap, out_ch.valid, out_ch.member_count <= DEPTH, "count above capacity")

endmodule
